@@ src/cpfa_pkg.sv @@
// Shared types, constants and codes of the chained page-frame allocator.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package cpfa_pkg;

    // Page geometry
    localparam int NUM_PAGES  = 1024;
    localparam int PAGE_SHIFT = 12;

    // Derived widths
    localparam int IDX_W   = $clog2(NUM_PAGES);   // page index
    localparam int CNT_W   = IDX_W + 1;           // page count, holds NUM_PAGES
    localparam int ENT_W   = CNT_W;               // map entry: free, link + 1, or end
    localparam int MEMB_W  = CNT_W + PAGE_SHIFT;  // byte size of managed memory

    // Port field widths
    localparam int CFG_W    = 11;
    localparam int BYTES_W  = 32;
    localparam int ADDR_W   = 32;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 11;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1024);

    // Map entry codes
    localparam logic [ENT_W-1:0] ENT_FREE = '0;
    localparam logic [ENT_W-1:0] ENT_END  = '1;

    // Request kinds
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOMEM    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTALLOC = 2'd2;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_SCAN_INIT,
        OP_COUNT,
        OP_BUILD,
        OP_TAIL,
        OP_FREE_INIT,
        OP_FREE_RD,
        OP_FREE_EV,
        OP_RESULT
    } op_t;

    // Controller to datapath
    typedef struct packed {
        op_t                 op;
        logic [STATUS_W-1:0] code;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;      // clearing pass at its last entry
        logic mode_free;     // captured request is a free
        logic too_big;       // allocate size at or above managed memory
        logic in_range;      // free start page inside managed pages
        logic have_eq_want;  // scan has found enough free pages
        logic scan_end;      // scan ran off the end with nothing in flight
        logic ent_free;      // entry read during free is free
        logic ent_stop;      // entry read during free ends the walk
        logic n_zero;        // nothing freed yet
        logic out_busy;      // result register held and not taken this cycle
    } sts_t;

endpackage

`default_nettype wire

@@ src/cpfa_ctrl.sv @@
// Controller state machine of the chained page-frame allocator.
// Depends on cpfa_pkg; drives cpfa_datapath through cmd_t and reads sts_t.
`timescale 1ns / 1ps
`default_nettype none

module cpfa_ctrl
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire cpfa_pkg::sts_t sts,
    output cpfa_pkg::cmd_t     cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_COUNT,
        S_BUILD,
        S_FREE_RD,
        S_FREE_EV,
        S_RESP
    } state_t;

    state_t                        state_reg, state_next;
    logic [cpfa_pkg::STATUS_W-1:0] code_reg, code_next;

    assign in_ready = (state_reg == S_IDLE);

    // Decode state and status into the next state and a datapath command
    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd.op     = cpfa_pkg::OP_NONE;
        cmd.code   = code_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.op = cpfa_pkg::OP_CLEAR;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = cpfa_pkg::OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (sts.mode_free)
                begin
                    if (!sts.in_range)
                    begin
                        code_next  = cpfa_pkg::ST_NOTALLOC;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        cmd.op     = cpfa_pkg::OP_FREE_INIT;
                        state_next = S_FREE_RD;
                    end
                end
                else if (sts.too_big)
                begin
                    code_next  = cpfa_pkg::ST_NOMEM;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.op     = cpfa_pkg::OP_SCAN_INIT;
                    state_next = S_COUNT;
                end
            end
            S_COUNT:
            begin
                if (sts.have_eq_want)
                begin
                    cmd.op     = cpfa_pkg::OP_SCAN_INIT;
                    state_next = S_BUILD;
                end
                else if (sts.scan_end)
                begin
                    code_next  = cpfa_pkg::ST_NOMEM;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.op = cpfa_pkg::OP_COUNT;
                end
            end
            S_BUILD:
            begin
                if (sts.have_eq_want)
                begin
                    cmd.op     = cpfa_pkg::OP_TAIL;
                    code_next  = cpfa_pkg::ST_OK;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.op = cpfa_pkg::OP_BUILD;
                end
            end
            S_FREE_RD:
            begin
                cmd.op     = cpfa_pkg::OP_FREE_RD;
                state_next = S_FREE_EV;
            end
            S_FREE_EV:
            begin
                cmd.op = cpfa_pkg::OP_FREE_EV;
                if (sts.ent_free)
                begin
                    code_next  = sts.n_zero ? cpfa_pkg::ST_NOTALLOC : cpfa_pkg::ST_OK;
                    state_next = S_RESP;
                end
                else if (sts.ent_stop)
                begin
                    code_next  = cpfa_pkg::ST_OK;
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_FREE_RD;
                end
            end
            S_RESP:
            begin
                if (!sts.out_busy)
                begin
                    cmd.op     = cpfa_pkg::OP_RESULT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and the pending status code
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            code_reg  <= cpfa_pkg::ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    // A result is never loaded over one still waiting to be taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == cpfa_pkg::OP_RESULT |-> !sts.out_busy)
        else $error("result loaded while previous result pending");

    // Out of memory only answers an allocate
    a_nomem_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == cpfa_pkg::OP_RESULT && cmd.code == cpfa_pkg::ST_NOMEM)
        |-> !sts.mode_free)
        else $error("out of memory reported for a free request");

    // No new transfer is taken during the clearing pass
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == cpfa_pkg::OP_CLEAR |-> !in_ready)
        else $error("input ready during clearing pass");

endmodule

`default_nettype wire

@@ src/cpfa_datapath.sv @@
// Datapath of the chained page-frame allocator: page map memory, scan and
// walk counters, request capture and result register. Depends on cpfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpfa_datapath
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire cpfa_pkg::cmd_t                cmd,
    output cpfa_pkg::sts_t                     sts,
    input  wire logic                          cfg_write_en,
    input  wire logic [cpfa_pkg::CFG_W-1:0]    cfg_write_data,
    input  wire logic                          mode,
    input  wire logic [cpfa_pkg::BYTES_W-1:0]  request_bytes,
    input  wire logic [cpfa_pkg::ADDR_W-1:0]   free_address,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [cpfa_pkg::STATUS_W-1:0]      status,
    output logic [cpfa_pkg::ADDR_W-1:0]        base_address,
    output logic [cpfa_pkg::TOTAL_W-1:0]       page_total
);

    // Page map
    logic [cpfa_pkg::ENT_W-1:0] map_mem [cpfa_pkg::NUM_PAGES];
    logic [cpfa_pkg::ENT_W-1:0] rd_data_reg;
    logic                       rd_en;
    logic [cpfa_pkg::IDX_W-1:0] rd_addr;
    logic                       wr_en;
    logic [cpfa_pkg::IDX_W-1:0] wr_addr;
    logic [cpfa_pkg::ENT_W-1:0] wr_data;

    // Configuration and request capture
    logic [cpfa_pkg::CFG_W-1:0] cfg_reg;
    logic                       mode_reg, mode_next;
    logic [cpfa_pkg::CNT_W-1:0] want_reg, want_next;
    logic                       too_big_reg, too_big_next;
    logic                       in_range_reg, in_range_next;
    logic [cpfa_pkg::IDX_W-1:0] page_reg, page_next;

    // Scan and walk state
    logic [cpfa_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic [cpfa_pkg::CNT_W-1:0] have_reg, have_next;
    logic                       started_reg, started_next;
    logic [cpfa_pkg::IDX_W-1:0] prev_reg, prev_next;
    logic [cpfa_pkg::IDX_W-1:0] first_reg, first_next;
    logic [cpfa_pkg::IDX_W-1:0] cur_reg, cur_next;
    logic [cpfa_pkg::CNT_W-1:0] n_reg, n_next;
    logic                       rd_vld_reg, rd_vld_next;
    logic [cpfa_pkg::IDX_W-1:0] rd_idx_reg, rd_idx_next;

    // Result register
    logic                          out_valid_reg, out_valid_next;
    logic [cpfa_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [cpfa_pkg::ADDR_W-1:0]   base_reg, base_next;
    logic [cpfa_pkg::TOTAL_W-1:0]  total_reg, total_next;

    // Derived values
    logic [cpfa_pkg::CNT_W-1:0]             eff_pages;
    logic [cpfa_pkg::MEMB_W-1:0]            mem_bytes;
    logic [cpfa_pkg::CNT_W-1:0]             want_raw;
    logic [cpfa_pkg::ADDR_W-cpfa_pkg::PAGE_SHIFT-1:0] page_full;
    logic                                   issue;
    logic                                   take;
    logic                                   ent_is_free;

    // Saturate the page count at the map depth
    always_comb
    begin
        if (32'(cfg_reg) > cpfa_pkg::NUM_PAGES)
        begin
            eff_pages = cpfa_pkg::CNT_W'(cpfa_pkg::NUM_PAGES);
        end
        else
        begin
            eff_pages = cpfa_pkg::CNT_W'(cfg_reg);
        end
    end

    assign mem_bytes   = {eff_pages, {cpfa_pkg::PAGE_SHIFT{1'b0}}};
    assign want_raw    = request_bytes[cpfa_pkg::PAGE_SHIFT +: cpfa_pkg::CNT_W]
                         + cpfa_pkg::CNT_W'(|request_bytes[cpfa_pkg::PAGE_SHIFT-1:0]);
    assign page_full   = free_address[cpfa_pkg::ADDR_W-1:cpfa_pkg::PAGE_SHIFT];
    assign issue       = idx_reg < eff_pages;
    assign ent_is_free = rd_data_reg == cpfa_pkg::ENT_FREE;
    assign take        = rd_vld_reg && ent_is_free && (have_reg != want_reg);

    // Status towards the controller
    assign sts.clr_last     = idx_reg == cpfa_pkg::CNT_W'(cpfa_pkg::NUM_PAGES - 1);
    assign sts.mode_free    = mode_reg == cpfa_pkg::MODE_FREE;
    assign sts.too_big      = too_big_reg;
    assign sts.in_range     = in_range_reg;
    assign sts.have_eq_want = have_reg == want_reg;
    assign sts.scan_end     = !issue && !rd_vld_reg;
    assign sts.ent_free     = ent_is_free;
    assign sts.ent_stop     = (rd_data_reg == cpfa_pkg::ENT_END)
                              || (rd_data_reg > cpfa_pkg::ENT_W'(cpfa_pkg::NUM_PAGES))
                              || (n_reg == cpfa_pkg::CNT_W'(cpfa_pkg::NUM_PAGES - 1));
    assign sts.n_zero       = n_reg == '0;
    assign sts.out_busy     = out_valid_reg && !out_ready;

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign base_address = base_reg;
    assign page_total   = total_reg;

    // Carry out the commanded operation
    always_comb
    begin
        rd_en          = 1'b0;
        rd_addr        = idx_reg[cpfa_pkg::IDX_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = prev_reg;
        wr_data        = cpfa_pkg::ENT_FREE;
        mode_next      = mode_reg;
        want_next      = want_reg;
        too_big_next   = too_big_reg;
        in_range_next  = in_range_reg;
        page_next      = page_reg;
        idx_next       = idx_reg;
        have_next      = have_reg;
        started_next   = started_reg;
        prev_next      = prev_reg;
        first_next     = first_reg;
        cur_next       = cur_reg;
        n_next         = n_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = rd_idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        base_next      = base_reg;
        total_next     = total_reg;

        case (cmd.op)
            cpfa_pkg::OP_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = idx_reg[cpfa_pkg::IDX_W-1:0];
                idx_next = idx_reg + 1'b1;
            end
            cpfa_pkg::OP_LOAD:
            begin
                mode_next     = mode;
                too_big_next  = request_bytes >= cpfa_pkg::BYTES_W'(mem_bytes);
                want_next     = (want_raw == '0) ? cpfa_pkg::CNT_W'(1) : want_raw;
                in_range_next = 32'(page_full) < 32'(eff_pages);
                page_next     = page_full[cpfa_pkg::IDX_W-1:0];
            end
            cpfa_pkg::OP_SCAN_INIT:
            begin
                idx_next     = '0;
                have_next    = '0;
                started_next = 1'b0;
            end
            cpfa_pkg::OP_COUNT:
            begin
                // issue the next read, count the entry returned last cycle
                rd_en       = issue;
                rd_vld_next = issue;
                rd_idx_next = idx_reg[cpfa_pkg::IDX_W-1:0];
                if (issue)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                if (take)
                begin
                    have_next = have_reg + 1'b1;
                end
            end
            cpfa_pkg::OP_BUILD:
            begin
                rd_en       = issue;
                rd_vld_next = issue;
                rd_idx_next = idx_reg[cpfa_pkg::IDX_W-1:0];
                if (issue)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                // link the previous page of the chain to this free one
                if (take)
                begin
                    if (started_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = prev_reg;
                        wr_data = cpfa_pkg::ENT_W'(rd_idx_reg) + 1'b1;
                    end
                    else
                    begin
                        first_next = rd_idx_reg;
                    end
                    started_next = 1'b1;
                    prev_next    = rd_idx_reg;
                    have_next    = have_reg + 1'b1;
                end
            end
            cpfa_pkg::OP_TAIL:
            begin
                wr_en   = 1'b1;
                wr_addr = prev_reg;
                wr_data = cpfa_pkg::ENT_END;
            end
            cpfa_pkg::OP_FREE_INIT:
            begin
                cur_next = page_reg;
                n_next   = '0;
            end
            cpfa_pkg::OP_FREE_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = cur_reg;
            end
            cpfa_pkg::OP_FREE_EV:
            begin
                // clear the visited entry and step along its link
                if (!ent_is_free)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = cur_reg;
                    wr_data  = cpfa_pkg::ENT_FREE;
                    n_next   = n_reg + 1'b1;
                    cur_next = cpfa_pkg::IDX_W'(rd_data_reg - 1'b1);
                end
            end
            cpfa_pkg::OP_RESULT:
            begin
                out_valid_next = 1'b1;
                status_next    = cmd.code;
                if (cmd.code == cpfa_pkg::ST_OK)
                begin
                    if (mode_reg == cpfa_pkg::MODE_FREE)
                    begin
                        base_next  = cpfa_pkg::ADDR_W'(page_reg) << cpfa_pkg::PAGE_SHIFT;
                        total_next = cpfa_pkg::TOTAL_W'(n_reg);
                    end
                    else
                    begin
                        base_next  = cpfa_pkg::ADDR_W'(first_reg) << cpfa_pkg::PAGE_SHIFT;
                        total_next = cpfa_pkg::TOTAL_W'(want_reg);
                    end
                end
                else
                begin
                    base_next  = '0;
                    total_next = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Page map: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            map_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= map_mem[rd_addr];
        end
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= cpfa_pkg::CFG_RESET;
        end
        else if (cfg_write_en)
        begin
            cfg_reg <= cfg_write_data;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= cpfa_pkg::MODE_ALLOC;
            too_big_reg   <= 1'b0;
            in_range_reg  <= 1'b0;
            idx_reg       <= '0;
            have_reg      <= '0;
            started_reg   <= 1'b0;
            n_reg         <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            too_big_reg   <= too_big_next;
            in_range_reg  <= in_range_next;
            idx_reg       <= idx_next;
            have_reg      <= have_next;
            started_reg   <= started_next;
            n_reg         <= n_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        want_reg   <= want_next;
        page_reg   <= page_next;
        prev_reg   <= prev_next;
        first_reg  <= first_next;
        cur_reg    <= cur_next;
        rd_idx_reg <= rd_idx_next;
        status_reg <= status_next;
        base_reg   <= base_next;
        total_reg  <= total_next;
    end

    // Scans never count past the wanted number of pages
    a_have_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == cpfa_pkg::OP_COUNT || cmd.op == cpfa_pkg::OP_BUILD)
        |-> have_reg <= want_reg)
        else $error("scan counted beyond wanted pages");

    // The chain end is only written once a first page has been taken
    a_tail_started: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == cpfa_pkg::OP_TAIL |-> started_reg)
        else $error("chain end written with no page taken");

    // A free step evaluates data read in the cycle before
    a_walk_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == cpfa_pkg::OP_FREE_EV |-> $past(cmd.op) == cpfa_pkg::OP_FREE_RD)
        else $error("free step without a preceding map read");

endmodule

`default_nettype wire

@@ src/chained_page_frame_allocator_top.sv @@
// Top level of the chained page-frame allocator.
// Depends on cpfa_pkg, cpfa_ctrl and cpfa_datapath.
`timescale 1ns / 1ps
`default_nettype none

// The allocator keeps a 1024-entry page map in a single memory with one write
// and one registered read port, and scans it one entry per cycle. After reset
// it runs a clearing pass over every map entry with in_ready low; configuration
// writes are still taken. A request is taken only when the block is idle, one
// at a time. An allocate passes through a dispatch step, a counting scan, a
// chaining scan and a result step; one that finds too few free pages is
// answered when the counting scan runs off the managed pages, and one rejected
// for its size is answered from dispatch. A free follows the chain through a
// read-then-follow loop, reading each entry through the map's registered read
// port before clearing it and stepping to its link; a free of a free page, or
// of one outside the managed pages, is answered as not allocated. A finished
// result waits in the output register while the next request is taken, and
// that request cannot post its result until the waiting one has been
// transferred.

module chained_page_frame_allocator_top
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write_en,
    input  wire logic [cpfa_pkg::CFG_W-1:0]    cfg_write_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          mode,
    input  wire logic [cpfa_pkg::BYTES_W-1:0]  request_bytes,
    input  wire logic [cpfa_pkg::ADDR_W-1:0]   free_address,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [cpfa_pkg::STATUS_W-1:0]      status,
    output logic [cpfa_pkg::ADDR_W-1:0]        base_address,
    output logic [cpfa_pkg::TOTAL_W-1:0]       page_total
);

    cpfa_pkg::cmd_t cmd;
    cpfa_pkg::sts_t sts;

    // Sequence requests
    cpfa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Hold the map, the request and the result
    cpfa_datapath u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .mode           (mode),
        .request_bytes  (request_bytes),
        .free_address   (free_address),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .base_address   (base_address),
        .page_total     (page_total)
    );

endmodule

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for chained_page_frame_allocator_top.
// Depends on cpfa_pkg and the allocator RTL; keeps its own page map and
// checks every allocate and free answer in order against it.

module tb;
    import cpfa_pkg::*;

    // Own page map encoding: free, last page of a chain, or next page + 1
    localparam int FRAME_FREE  = 0;
    localparam int FRAME_LAST  = -1;
    localparam int PAGE_BYTES  = 1 << PAGE_SHIFT;
    localparam longint TIMEOUT_NS = 8_000_000;
    localparam int TAIL_CYCLES = 2 * NUM_PAGES + 64;

    typedef struct {
        logic               kind;
        logic [BYTES_W-1:0] bytes;
        logic [ADDR_W-1:0]  addr;
    } frame_request_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   base;
        logic [TOTAL_W-1:0]  pages;
    } frame_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_write_en = 1'b0;
    logic [CFG_W-1:0]    cfg_write_data = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic                mode = MODE_ALLOC;
    logic [BYTES_W-1:0]  request_bytes = '0;
    logic [ADDR_W-1:0]   free_address = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   base_address;
    logic [TOTAL_W-1:0]  page_total;

    // Predicted allocator state
    int               frame_link [NUM_PAGES];
    logic [CFG_W-1:0] managed_pages = CFG_RESET;
    int               live_bases[$];

    frame_request_t pending_requests[$];
    frame_result_t  expected_results[$];
    int             requests_open = 0;
    int             mismatches = 0;
    int             send_idle_pct = 0;
    int             recv_stall_pct = 0;
    logic           in_taken = 1'b0;

    int requests_seen = 0;
    int allocs_granted = 0;
    int frees_granted = 0;
    int nomem_answers = 0;
    int notalloc_answers = 0;

    chained_page_frame_allocator_top dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .request_bytes  (request_bytes),
        .free_address   (free_address),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .base_address   (base_address),
        .page_total     (page_total)
    );

    always #1 clk = ~clk;

    function automatic int usable_pages();
        return (managed_pages > NUM_PAGES) ? NUM_PAGES : int'(managed_pages);
    endfunction

    // Take the lowest free pages, chain them in ascending order
    function automatic frame_result_t grant_alloc(input logic [BYTES_W-1:0] bytes);
        frame_result_t r;
        logic [63:0]   bytes64;
        int            avail;
        int            want;
        int            found;
        int            first;
        int            prev;
        int            i;
        r = '{ST_NOMEM, '0, '0};
        avail = usable_pages();
        bytes64 = {32'd0, bytes};
        if (bytes64 >= (64'(avail) << PAGE_SHIFT))
            return r;
        want = int'((bytes64 + PAGE_BYTES - 1) >> PAGE_SHIFT);
        if (want == 0)
            want = 1;
        found = 0;
        for (i = 0; i < avail && found < want; i++)
            if (frame_link[i] == FRAME_FREE)
                found++;
        if (found < want)
            return r;
        found = 0;
        first = -1;
        prev = -1;
        for (i = 0; i < avail && found < want; i++)
        begin
            if (frame_link[i] == FRAME_FREE)
            begin
                if (prev >= 0)
                    frame_link[prev] = i + 1;
                else
                    first = i;
                frame_link[i] = FRAME_LAST;
                prev = i;
                found++;
            end
        end
        live_bases.push_back(first);
        r = '{ST_OK, ADDR_W'(first) << PAGE_SHIFT, TOTAL_W'(want)};
        return r;
    endfunction

    // Walk the chain from the addressed page and clear every entry on it
    function automatic frame_result_t release_chain(input logic [ADDR_W-1:0] addr);
        frame_result_t r;
        int            page;
        int            walk;
        int            link;
        int            freed;
        int            i;
        r = '{ST_NOTALLOC, '0, '0};
        page = int'(addr >> PAGE_SHIFT);
        if (page >= usable_pages() || frame_link[page] == FRAME_FREE)
            return r;
        walk = page;
        freed = 0;
        while (freed < NUM_PAGES)
        begin
            link = frame_link[walk];
            if (link == FRAME_FREE)
                break;
            frame_link[walk] = FRAME_FREE;
            freed++;
            if (link == FRAME_LAST)
                break;
            walk = link - 1;
        end
        for (i = 0; i < live_bases.size(); i++)
        begin
            if (live_bases[i] == page)
            begin
                live_bases.delete(i);
                break;
            end
        end
        r = '{ST_OK, ADDR_W'(page) << PAGE_SHIFT, TOTAL_W'(freed)};
        return r;
    endfunction

    function automatic int find_used_page(input int start);
        int j;
        int p;
        for (j = 0; j < NUM_PAGES; j++)
        begin
            p = (start + j) % NUM_PAGES;
            if (frame_link[p] != FRAME_FREE)
                return p;
        end
        return -1;
    endfunction

    // Check each result transfer, then predict each request transfer
    always @(posedge clk)
    begin
        frame_result_t got;
        frame_result_t want_r;
        if (rst_n)
        begin
            if (cfg_write_en)
                managed_pages = cfg_write_data;
            if (out_valid && out_ready)
            begin
                got = '{status, base_address, page_total};
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result with none expected, actual status=%0d base=%h pages=%0d",
                             $time, got.status, got.base, got.pages);
                end
                else
                begin
                    want_r = expected_results.pop_front();
                    requests_open--;
                    if (got.status !== want_r.status || got.base !== want_r.base ||
                        got.pages !== want_r.pages)
                    begin
                        mismatches++;
                        $display("%0t: expected status=%0d base=%h pages=%0d, actual status=%0d base=%h pages=%0d",
                                 $time, want_r.status, want_r.base, want_r.pages,
                                 got.status, got.base, got.pages);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (mode == MODE_ALLOC)
                    want_r = grant_alloc(request_bytes);
                else
                    want_r = release_chain(free_address);
                expected_results.push_back(want_r);
                requests_seen++;
                if (want_r.status == ST_OK && mode == MODE_ALLOC)
                    allocs_granted++;
                else if (want_r.status == ST_OK)
                    frees_granted++;
                else if (want_r.status == ST_NOMEM)
                    nomem_answers++;
                else
                    notalloc_answers++;
            end
            in_taken <= in_valid && in_ready;
        end
    end

    // Drive requests and result back-pressure on the falling edge
    always @(negedge clk)
    begin
        frame_request_t next_req;
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (!(in_valid && !in_taken))
        begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_req = pending_requests.pop_front();
                in_valid      <= 1'b1;
                mode          <= next_req.kind;
                request_bytes <= next_req.bytes;
                free_address  <= next_req.addr;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    task automatic queue_request(input logic kind, input logic [BYTES_W-1:0] bytes,
                                 input logic [ADDR_W-1:0] addr);
        frame_request_t r;
        r.kind = kind;
        r.bytes = bytes;
        r.addr = addr;
        pending_requests.push_back(r);
        requests_open++;
    endtask

    task automatic wait_drained();
        while (requests_open != 0)
            @(negedge clk);
    endtask

    task automatic set_managed_pages(input int pages);
        wait_drained();
        cfg_write_data <= CFG_W'(pages);
        cfg_write_en <= 1'b1;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        @(negedge clk);
    endtask

    // Mostly well-sized allocations and frees of live chains, some noise
    task automatic queue_random_request();
        int               avail;
        int               span;
        int               k;
        int               pick;
        int               page;
        logic [BYTES_W-1:0] bytes;
        logic [ADDR_W-1:0]  addr;
        avail = usable_pages();
        pick = $urandom_range(99);
        if ($urandom_range(99) < 55)
        begin
            span = avail / 4;
            if (span > 64)
                span = 64;
            if (span < 1)
                span = 1;
            k = $urandom_range(1, span);
            if (pick < 5)
                bytes = '0;
            else if (pick < 65)
                bytes = BYTES_W'((k - 1) * PAGE_BYTES + $urandom_range(1, PAGE_BYTES));
            else if (pick < 80)
                bytes = BYTES_W'(k * PAGE_BYTES);
            else if (pick < 92)
                bytes = BYTES_W'(avail * PAGE_BYTES) -
                        BYTES_W'($urandom_range(0, 2 * PAGE_BYTES));
            else
                bytes = $urandom;
            queue_request(MODE_ALLOC, bytes, $urandom);
        end
        else
        begin
            page = -1;
            if (pick < 55 && live_bases.size() != 0)
                page = live_bases[$urandom_range(live_bases.size() - 1)];
            else if (pick < 75)
                page = find_used_page($urandom_range(NUM_PAGES - 1));
            else if (pick < 90)
                page = $urandom_range(NUM_PAGES - 1);
            if (page < 0)
                addr = $urandom;
            else
                addr = (ADDR_W'(page) << PAGE_SHIFT) | ADDR_W'($urandom_range(PAGE_BYTES - 1));
            queue_request(MODE_FREE, $urandom, addr);
        end
    endtask

    task automatic run_phase(input int pages, input int send_pct, input int recv_pct,
                             input int count);
        int n;
        set_managed_pages(pages);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        for (n = 0; n < count; n++)
        begin
            while (pending_requests.size() >= 2)
                @(negedge clk);
            // hold back the sender until every answer is in
            if (n == count / 2)
                wait_drained();
            queue_random_request();
        end
    endtask

    initial
    begin
        #(TIMEOUT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: size rounding, limits, fragmented and partial chains
        queue_request(MODE_ALLOC, 32'd0, 32'd0);
        queue_request(MODE_ALLOC, 32'd1, 32'd0);
        queue_request(MODE_ALLOC, 32'd4096, 32'd0);
        queue_request(MODE_ALLOC, 32'd4097, 32'd0);
        queue_request(MODE_ALLOC, 32'hFFFF_FFFF, 32'd0);
        queue_request(MODE_ALLOC, 32'(NUM_PAGES * PAGE_BYTES), 32'd0);
        queue_request(MODE_ALLOC, 32'(NUM_PAGES * PAGE_BYTES - 1), 32'd0);
        queue_request(MODE_FREE, 32'd0, 32'h0000_3ABC);
        queue_request(MODE_FREE, 32'd0, 32'h0000_3000);
        queue_request(MODE_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_request(MODE_FREE, 32'd0, 32'(500 * PAGE_BYTES));
        queue_request(MODE_FREE, 32'd0, 32'h0000_1FFF);
        queue_request(MODE_ALLOC, 32'(3 * PAGE_BYTES), 32'd0);
        queue_request(MODE_FREE, 32'd0, 32'h0000_3000);
        queue_request(MODE_FREE, 32'd0, 32'h0000_1000);
        queue_request(MODE_ALLOC, 32'(8 * PAGE_BYTES), 32'd0);

        // Lowered limit: the chain still runs past it while freed
        set_managed_pages(2);
        queue_request(MODE_FREE, 32'd0, 32'h0000_1000);
        queue_request(MODE_ALLOC, 32'd0, 32'd0);
        queue_request(MODE_ALLOC, 32'(2 * PAGE_BYTES), 32'd0);

        // No pages managed at all
        set_managed_pages(0);
        queue_request(MODE_ALLOC, 32'd0, 32'd0);
        queue_request(MODE_FREE, 32'd0, 32'd0);

        // Register above the map size saturates
        set_managed_pages(2047);
        queue_request(MODE_ALLOC, 32'(2 * PAGE_BYTES + 1), 32'd0);
        queue_request(MODE_ALLOC, 32'(NUM_PAGES * PAGE_BYTES - 1), 32'd0);

        run_phase(16, 0, 0, 40);
        run_phase(64, 83, 0, 40);
        run_phase(1024, 0, 83, 45);
        run_phase(2047, 36, 36, 30);
        run_phase(3, 36, 36, 20);
        run_phase(200, 0, 0, 35);
        run_phase(40, 36, 36, 30);
        run_phase(1, 83, 0, 15);
        run_phase(1024, 0, 0, 35);

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Ran %0d requests under page limits from 0 to 2047 and four idling patterns:",
                 requests_seen);
        $display("%0d allocations and %0d frees granted, %0d out of memory, %0d not allocated.",
                 allocs_granted, frees_granted, nomem_answers, notalloc_answers);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
